// File: rtl/rrbp_pkg.sv
// shared types and constants for the reply byte parser
// no dependencies; imported by every module of the block
`default_nettype none

package rrbp_pkg;

	localparam int LENGTH_BITS_DEF = 30;
	localparam int OUT_LEN_W       = 30;
	localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = '1;

	// protocol bytes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// event kinds
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_BYTE = 2'd1;
	localparam logic [1:0] EV_DONE = 2'd2;
	localparam logic [1:0] EV_ERR  = 2'd3;

	// element types
	localparam logic [2:0] TY_SIMPLE = 3'd0;
	localparam logic [2:0] TY_ERROR  = 3'd1;
	localparam logic [2:0] TY_INT    = 3'd2;
	localparam logic [2:0] TY_BULK   = 3'd3;
	localparam logic [2:0] TY_NULL   = 3'd4;

	// line kinds of an open simple line
	localparam logic [1:0] LK_SIMPLE = 2'd0;
	localparam logic [1:0] LK_ERROR  = 2'd1;
	localparam logic [1:0] LK_INT    = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LINE,
		PH_BHDR,
		PH_AHDR,
		PH_BODY,
		PH_TRAIL,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic negative;
		logic finished;
		logic started;
	} num_flags_t;

	typedef struct packed {
		logic                 idle;
		logic [OUT_LEN_W-1:0] element_length;
		logic [2:0]           element_type;
		logic [7:0]           payload_byte;
		logic [1:0]           event_kind;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/rrbp_number.sv
// one step of the header number reader (atoi style, saturating)
// depends on rrbp_pkg
`default_nettype none

module rrbp_number #(
	parameter int LENGTH_BITS = rrbp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic [7:0]             data_byte,
	input  wire logic [LENGTH_BITS-1:0] value,
	input  wire rrbp_pkg::num_flags_t   flags,
	output logic [LENGTH_BITS-1:0]      value_d,
	output rrbp_pkg::num_flags_t        flags_d
);
	import rrbp_pkg::*;

	logic                   is_digit;
	logic                   is_space;
	logic                   is_sign;
	logic [LENGTH_BITS+3:0] prod;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
		(data_byte == CH_VT) || (data_byte == CH_FF);
	assign is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);

	// value * 10 + digit, saturates when it spills over the top bits
	assign prod = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} +
		(LENGTH_BITS+4)'(data_byte[3:0]);

	always_comb begin
		value_d = value;
		flags_d = flags;
		if (!flags.finished) begin
			if (is_digit) begin
				flags_d.started = 1'b1;
				if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
					value_d = '1;
				end else begin
					value_d = prod[LENGTH_BITS-1:0];
				end
			end else if (!flags.started && is_space) begin
				flags_d = flags;
			end else if (!flags.started && is_sign) begin
				flags_d.started  = 1'b1;
				flags_d.negative = (data_byte == CH_MINUS);
			end else begin
				flags_d.started  = 1'b1;
				flags_d.finished = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rrbp_step.sv
// per-byte parser step: next phase, state updates and the result word
// depends on rrbp_pkg and rrbp_number
`default_nettype none

module rrbp_step #(
	parameter int LENGTH_BITS = rrbp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic [7:0]             data_byte,
	input  wire rrbp_pkg::phase_t       phase,
	input  wire logic [1:0]             line_kind,
	input  wire logic [LENGTH_BITS-1:0] byte_count,
	input  wire logic [LENGTH_BITS-1:0] number_value,
	input  wire rrbp_pkg::num_flags_t   num_flags,
	output rrbp_pkg::phase_t            phase_d,
	output logic [1:0]                  line_kind_d,
	output logic [LENGTH_BITS-1:0]      byte_count_d,
	output logic [LENGTH_BITS-1:0]      number_value_d,
	output rrbp_pkg::num_flags_t        num_flags_d,
	output rrbp_pkg::result_t           result
);
	import rrbp_pkg::*;

	localparam int EXT_W = (LENGTH_BITS > OUT_LEN_W) ? LENGTH_BITS : OUT_LEN_W;
	localparam logic [LENGTH_BITS-1:0] LEN_CAP = {1'b1, {(LENGTH_BITS-1){1'b0}}};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	logic                   is_cr;
	logic                   is_lf;
	logic                   is_line_open;
	logic                   hdr_null;
	logic                   hdr_bad;
	logic [LENGTH_BITS-1:0] cnt_inc;
	logic [LENGTH_BITS-1:0] num_next;
	num_flags_t             flags_next;
	logic [EXT_W-1:0]       cnt_ext;
	logic [EXT_W-1:0]       num_ext;
	logic [OUT_LEN_W-1:0]   cnt_out;
	logic [OUT_LEN_W-1:0]   num_out;
	logic [1:0]             ev;
	logic [7:0]             pb;
	logic [2:0]             ty;
	logic [OUT_LEN_W-1:0]   len;

	rrbp_number #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_number (
		.data_byte(data_byte),
		.value    (number_value),
		.flags    (num_flags),
		.value_d  (num_next),
		.flags_d  (flags_next)
	);

	assign is_cr        = (data_byte == CH_CR);
	assign is_lf        = (data_byte == CH_LF);
	assign is_line_open = (data_byte == CH_PLUS) || (data_byte == CH_MINUS) ||
		(data_byte == CH_COLON);
	assign hdr_null     = num_flags.negative && (number_value == LEN_ONE);
	assign hdr_bad      = (num_flags.negative && (number_value != '0)) ||
		(number_value > LEN_CAP);
	assign cnt_inc      = byte_count + LEN_ONE;

	// clamp lengths to the 30-bit output field
	assign cnt_ext = EXT_W'(byte_count);
	assign num_ext = EXT_W'(number_value);
	assign cnt_out = (cnt_ext > EXT_W'(OUT_LEN_MAX)) ? OUT_LEN_MAX : cnt_ext[OUT_LEN_W-1:0];
	assign num_out = (num_ext > EXT_W'(OUT_LEN_MAX)) ? OUT_LEN_MAX : num_ext[OUT_LEN_W-1:0];

	// next phase
	always_comb begin
		phase_d = phase;
		case (phase)
			PH_IDLE: begin
				if (is_line_open) begin
					phase_d = PH_LINE;
				end else if (data_byte == CH_DOLLAR) begin
					phase_d = PH_BHDR;
				end else if (data_byte == CH_STAR) begin
					phase_d = PH_AHDR;
				end else if (!is_cr && !is_lf) begin
					phase_d = PH_ERR;
				end
			end
			PH_LINE: begin
				if (is_lf) begin
					phase_d = PH_IDLE;
				end
			end
			PH_BHDR: begin
				if (is_lf) begin
					if (hdr_null) begin
						phase_d = PH_IDLE;
					end else if (hdr_bad) begin
						phase_d = PH_ERR;
					end else if (number_value == '0) begin
						phase_d = PH_TRAIL;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_AHDR: begin
				if (is_lf) begin
					phase_d = PH_IDLE;
				end
			end
			PH_BODY: begin
				if (cnt_inc >= number_value) begin
					phase_d = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				if (is_lf) begin
					phase_d = PH_IDLE;
				end else if (!is_cr) begin
					phase_d = PH_ERR;
				end
			end
			default: phase_d = PH_ERR;
		endcase
	end

	// state updates and events
	always_comb begin
		line_kind_d    = line_kind;
		byte_count_d   = byte_count;
		number_value_d = number_value;
		num_flags_d    = num_flags;
		ev             = EV_NONE;
		pb             = 8'h00;
		ty             = TY_SIMPLE;
		len            = '0;
		case (phase)
			PH_IDLE: begin
				if (is_line_open) begin
					if (data_byte == CH_PLUS) begin
						line_kind_d = LK_SIMPLE;
					end else if (data_byte == CH_MINUS) begin
						line_kind_d = LK_ERROR;
					end else begin
						line_kind_d = LK_INT;
					end
					byte_count_d = '0;
				end else if (data_byte == CH_DOLLAR) begin
					byte_count_d   = '0;
					number_value_d = '0;
					num_flags_d    = '0;
				end
			end
			PH_LINE: begin
				if (is_lf) begin
					ev           = EV_DONE;
					ty           = {1'b0, line_kind};
					len          = cnt_out;
					byte_count_d = '0;
				end else if (!is_cr) begin
					ev = EV_BYTE;
					pb = data_byte;
					ty = {1'b0, line_kind};
					if (byte_count < LEN_CAP) begin
						byte_count_d = cnt_inc;
					end
				end
			end
			PH_BHDR: begin
				if (is_lf) begin
					if (hdr_null) begin
						ev             = EV_DONE;
						ty             = TY_NULL;
						byte_count_d   = '0;
						number_value_d = '0;
						num_flags_d    = '0;
					end else if (!hdr_bad) begin
						byte_count_d = '0;
					end
				end else if (!is_cr) begin
					number_value_d = num_next;
					num_flags_d    = flags_next;
				end
			end
			PH_BODY: begin
				ev           = EV_BYTE;
				pb           = data_byte;
				ty           = TY_BULK;
				byte_count_d = cnt_inc;
			end
			PH_TRAIL: begin
				if (is_lf) begin
					ev             = EV_DONE;
					ty             = TY_BULK;
					len            = num_out;
					byte_count_d   = '0;
					number_value_d = '0;
					num_flags_d    = '0;
				end
			end
			default: begin
				ev = EV_NONE;
			end
		endcase
	end

	// sticky error wipes the payload fields
	always_comb begin
		result.event_kind     = ev;
		result.payload_byte   = pb;
		result.element_type   = ty;
		result.element_length = len;
		result.idle           = (phase_d == PH_IDLE);
		if (phase_d == PH_ERR) begin
			result.event_kind     = EV_ERR;
			result.payload_byte   = 8'h00;
			result.element_type   = TY_SIMPLE;
			result.element_length = '0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rrbp_out_reg.sv
// result register on the master side; frees up as soon as its word is taken
// depends on rrbp_pkg
`default_nettype none

module rrbp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire rrbp_pkg::result_t load_data,
	output logic                   space,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rrbp_pkg::result_t      out_data
);
	import rrbp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/resp_reply_byte_parser.sv
// reply byte parser top level: parser state registers, step logic, result register
// depends on rrbp_pkg, rrbp_step, rrbp_out_reg
//
// usage
//  - slave side takes one reply byte per word (s_tdata), s_tlast marks the
//    last byte of a received chunk; the idle bit of that word's result tells
//    whether the reply so far is complete
//  - master side gives exactly one result word per input byte, in order
//  - the result of a byte is registered in the result register at the edge that accepts it;
//    throughput: one byte per cycle while the result register has space, set by the
//    combinational parser step that updates the phase and counters
//  - s_tready is high while the result register is empty or being drained,
//    so a stalled receiver holds off the sender one word later, no loss
//  - reset puts the parser between elements with all counters cleared and
//    the result register empty
//  - a protocol error is sticky: every later word reports an error until reset
`default_nettype none

module resp_reply_byte_parser #(
	parameter int LENGTH_BITS = rrbp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // chunk_end
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] payload_byte, [37:8] element_length,
	                                    // [38] idle, [39] zero
	output logic [4:0]       m_tuser    // [1:0] event_kind, [4:2] element_type
);
	import rrbp_pkg::*;

	// parser state
	phase_t                 phase_q;
	logic [1:0]             line_kind_q;
	logic [LENGTH_BITS-1:0] byte_count_q;
	logic [LENGTH_BITS-1:0] number_value_q;
	num_flags_t             num_flags_q;

	phase_t                 phase_d;
	logic [1:0]             line_kind_d;
	logic [LENGTH_BITS-1:0] byte_count_d;
	logic [LENGTH_BITS-1:0] number_value_d;
	num_flags_t             num_flags_d;

	result_t step_res;
	result_t out_res;
	logic    space;
	logic    s_fire;
	logic    chunk_end;

	// chunk_end carries no behavior; the idle bit of every result is valid
	assign chunk_end = s_tlast;
	assign s_tready  = space;
	assign s_fire    = s_tvalid && space && (chunk_end || !chunk_end);

	rrbp_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.data_byte     (s_tdata),
		.phase         (phase_q),
		.line_kind     (line_kind_q),
		.byte_count    (byte_count_q),
		.number_value  (number_value_q),
		.num_flags     (num_flags_q),
		.phase_d       (phase_d),
		.line_kind_d   (line_kind_d),
		.byte_count_d  (byte_count_d),
		.number_value_d(number_value_d),
		.num_flags_d   (num_flags_d),
		.result        (step_res)
	);

	// state advances once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			line_kind_q    <= LK_SIMPLE;
			byte_count_q   <= '0;
			number_value_q <= '0;
			num_flags_q    <= '0;
		end else if (s_fire) begin
			phase_q        <= phase_d;
			line_kind_q    <= line_kind_d;
			byte_count_q   <= byte_count_d;
			number_value_q <= number_value_d;
			num_flags_q    <= num_flags_d;
		end
	end

	rrbp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s_fire),
		.load_data(step_res),
		.space    (space),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	// pack the result word
	assign m_tdata = {1'b0, out_res.idle, out_res.element_length, out_res.payload_byte};
	assign m_tuser = {out_res.element_type, out_res.event_kind};

endmodule

`default_nettype wire

// File: bench/resp_reply_byte_parser_tb.sv
// self-checking bench for the reply byte parser: directed replies, then random
// well-formed replies with random gaps on both sides, ending in one sticky error
// depends on rrbp_pkg and resp_reply_byte_parser
`default_nettype none

import rrbp_pkg::*;

// tracks the parser state and the result words it must give, in order
class reply_scoreboard;
	localparam int LEN_BITS = LENGTH_BITS_DEF;
	localparam longint unsigned LEN_CAP = 64'd1 << (LEN_BITS - 1);
	localparam longint unsigned NUM_SAT = (64'd1 << LEN_BITS) - 1;
	localparam longint unsigned LEN_OUT_MAX = (64'd1 << OUT_LEN_W) - 1;

	phase_t          phase;
	logic [1:0]      line_kind;
	longint unsigned byte_count;
	longint unsigned number_value;
	bit              num_negative;
	bit              num_finished;
	bit              num_started;
	result_t         expected_words[$];
	int              mismatches;

	function new();
		phase = PH_IDLE;
		line_kind = LK_SIMPLE;
		clear_number();
		mismatches = 0;
	endfunction

	function void clear_number();
		number_value = 0;
		num_negative = 0;
		num_finished = 0;
		num_started = 0;
		byte_count = 0;
	endfunction

	// atoi-style header digit handling
	function void header_char(logic [7:0] c);
		longint unsigned d;
		if (num_finished)
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = longint'(c - CH_ZERO);
			num_started = 1;
			if (number_value > (NUM_SAT - d) / 10)
				number_value = NUM_SAT;
			else
				number_value = number_value * 10 + d;
		end else if (!num_started && (c == CH_SPACE || c == CH_TAB || c == CH_VT
				|| c == CH_FF)) begin
			// leading white space
		end else if (!num_started && (c == CH_PLUS || c == CH_MINUS)) begin
			num_started = 1;
			num_negative = (c == CH_MINUS);
		end else begin
			num_started = 1;
			num_finished = 1;
		end
	endfunction

	function logic [OUT_LEN_W-1:0] clip_length(longint unsigned v);
		return (v > LEN_OUT_MAX) ? LEN_OUT_MAX[OUT_LEN_W-1:0] : v[OUT_LEN_W-1:0];
	endfunction

	// one accepted byte gives one word; chunk_end does not change it
	function void note_byte(logic [7:0] c);
		result_t w;
		w = '0;
		case (phase)
			PH_IDLE: begin
				if (c == CH_PLUS || c == CH_MINUS || c == CH_COLON) begin
					line_kind = (c == CH_PLUS) ? LK_SIMPLE :
						(c == CH_MINUS) ? LK_ERROR : LK_INT;
					byte_count = 0;
					phase = PH_LINE;
				end else if (c == CH_DOLLAR) begin
					clear_number();
					phase = PH_BHDR;
				end else if (c == CH_STAR) begin
					phase = PH_AHDR;
				end else if (c != CH_CR && c != CH_LF) begin
					phase = PH_ERR;
				end
			end
			PH_LINE: begin
				if (c == CH_LF) begin
					w.event_kind = EV_DONE;
					w.element_type = {1'b0, line_kind};
					w.element_length = clip_length(byte_count);
					byte_count = 0;
					phase = PH_IDLE;
				end else if (c != CH_CR) begin
					w.event_kind = EV_BYTE;
					w.payload_byte = c;
					w.element_type = {1'b0, line_kind};
					if (byte_count < LEN_CAP)
						byte_count++;
				end
			end
			PH_BHDR: begin
				if (c == CH_LF) begin
					if (num_negative && number_value == 1) begin
						w.event_kind = EV_DONE;
						w.element_type = TY_NULL;
						clear_number();
						phase = PH_IDLE;
					end else if ((num_negative && number_value != 0)
							|| number_value > LEN_CAP) begin
						phase = PH_ERR;
					end else begin
						byte_count = 0;
						phase = (number_value == 0) ? PH_TRAIL : PH_BODY;
					end
				end else if (c != CH_CR) begin
					header_char(c);
				end
			end
			PH_AHDR: begin
				if (c == CH_LF)
					phase = PH_IDLE;
			end
			PH_BODY: begin
				w.event_kind = EV_BYTE;
				w.payload_byte = c;
				w.element_type = TY_BULK;
				byte_count++;
				if (byte_count >= number_value)
					phase = PH_TRAIL;
			end
			PH_TRAIL: begin
				if (c == CH_LF) begin
					w.event_kind = EV_DONE;
					w.element_type = TY_BULK;
					w.element_length = clip_length(number_value);
					clear_number();
					phase = PH_IDLE;
				end else if (c != CH_CR) begin
					phase = PH_ERR;
				end
			end
			default: phase = PH_ERR;
		endcase
		if (phase == PH_ERR) begin
			w = '0;
			w.event_kind = EV_ERR;
		end
		w.idle = (phase == PH_IDLE);
		expected_words.push_back(w);
	endfunction

	function void compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_word(logic [39:0] tdata, logic [4:0] tuser);
		result_t w;
		if (expected_words.size() == 0) begin
			$display("%0t: result word expected none actual tdata 0x%0h tuser 0x%0h",
				$time, tdata, tuser);
			mismatches++;
			return;
		end
		w = expected_words.pop_front();
		compare_field("event_kind", w.event_kind, tuser[1:0]);
		compare_field("element_type", w.element_type, tuser[4:2]);
		compare_field("payload_byte", w.payload_byte, tdata[7:0]);
		compare_field("element_length", w.element_length, tdata[37:8]);
		compare_field("idle", w.idle, tdata[38]);
		compare_field("pad bit", 0, tdata[39]);
	endfunction

	function int pending();
		return expected_words.size();
	endfunction
endclass

module resp_reply_byte_parser_tb;

	localparam int RANDOM_BYTES = 1200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam longint unsigned BULK_LEN_MAX = 64'd1 << (LENGTH_BITS_DEF - 1);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [4:0]  m_tuser;

	reply_scoreboard sb;
	logic [7:0] reply_bytes[$];  // bytes waiting to be sent
	int  bytes_sent = 0;
	int  cycle_count = 0;
	int  rx_hold = 0;
	bit  tx_steady = 0;
	bit  rx_steady = 0;

	resp_reply_byte_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("resp_reply_byte_parser verification failed");
			$finish;
		end
	end

	// receiver: check each word, then stall for a random while unless rx_steady is set
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				sb.check_word(m_tdata, m_tuser);
				rx_hold = rx_steady ? 0 : $urandom_range(0, 9);
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			m_tready <= (rx_hold == 0);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic chunk_end);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= chunk_end;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_queued();
		while (reply_bytes.size() != 0)
			send_byte(reply_bytes.pop_front(), $urandom_range(0, 3) == 0);
	endtask

	// lower valid and wait until every word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			reply_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] byte_not_lf();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
		return b;
	endfunction

	// optional cr, then lf
	task automatic queue_line_end();
		if ($urandom_range(0, 2) != 0)
			reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
	endtask

	task automatic queue_header_pad();
		repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0) begin
			case ($urandom_range(0, 3))
				0: reply_bytes.push_back(CH_SPACE);
				1: reply_bytes.push_back(CH_TAB);
				2: reply_bytes.push_back(CH_VT);
				default: reply_bytes.push_back(CH_FF);
			endcase
		end
	endtask

	// junk after the number: a terminator and a few ignored bytes
	task automatic queue_header_junk();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) begin
			do b = 8'($urandom_range(0, 255));
			while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR || b == CH_LF);
			reply_bytes.push_back(b);
			repeat ($urandom_range(0, 3)) reply_bytes.push_back(byte_not_lf());
		end
	endtask

	// one well-formed element with random content, maybe after stray cr/lf
	task automatic queue_element();
		int n;
		int pick;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
			reply_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// simple string, error or integer line
			case ($urandom_range(0, 2))
				0: reply_bytes.push_back(CH_PLUS);
				1: reply_bytes.push_back(CH_MINUS);
				default: reply_bytes.push_back(CH_COLON);
			endcase
			repeat ($urandom_range(0, 10)) reply_bytes.push_back(byte_not_lf());
			queue_line_end();
		end else if (pick < 78) begin
			// bulk string, mostly short bodies
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 260) : $urandom_range(0, 12);
			reply_bytes.push_back(CH_DOLLAR);
			queue_header_pad();
			if (n == 0 && $urandom_range(0, 2) == 0)
				reply_bytes.push_back(CH_MINUS);
			else if ($urandom_range(0, 3) == 0)
				reply_bytes.push_back(CH_PLUS);
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
				reply_bytes.push_back(CH_ZERO);
			queue_text($sformatf("%0d", n));
			queue_header_junk();
			queue_line_end();
			repeat (n) reply_bytes.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 2)) reply_bytes.push_back(CH_CR);
			reply_bytes.push_back(CH_LF);
		end else if (pick < 88) begin
			// null bulk, minus one in any atoi spelling
			reply_bytes.push_back(CH_DOLLAR);
			queue_header_pad();
			reply_bytes.push_back(CH_MINUS);
			repeat ($urandom_range(0, 1)) reply_bytes.push_back(CH_ZERO);
			queue_text("1");
			queue_header_junk();
			queue_line_end();
		end else begin
			// array header, dropped without events
			reply_bytes.push_back(CH_STAR);
			repeat ($urandom_range(0, 6)) reply_bytes.push_back(byte_not_lf());
			reply_bytes.push_back(CH_LF);
		end
	endtask

	// one way into the sticky error state, then noise
	task automatic queue_error_tail();
		logic [7:0] b;
		case ($urandom_range(0, 4))
			0: begin
				// stray byte between elements
				do b = 8'($urandom_range(0, 255));
				while (b == CH_PLUS || b == CH_MINUS || b == CH_COLON || b == CH_DOLLAR
					|| b == CH_STAR || b == CH_CR || b == CH_LF);
				reply_bytes.push_back(b);
			end
			1: begin
				// negative length other than minus one
				queue_text($sformatf("$-%0d", $urandom_range(2, 999)));
				queue_line_end();
			end
			2: begin
				// just above the largest bulk length
				queue_text($sformatf("$%0d", BULK_LEN_MAX + $urandom_range(1, 1000)));
				queue_line_end();
			end
			3: begin
				// header number saturates
				queue_text("$999999999999");
				queue_line_end();
			end
			default: begin
				// bad byte in place of the trailer
				queue_text("$1");
				queue_line_end();
				reply_bytes.push_back(8'($urandom_range(0, 255)));
				do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
				reply_bytes.push_back(b);
			end
		endcase
		repeat (8) reply_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		bit held;
		held = 0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: stray cr lf, each line kind, null, -0 bulk, empty array,
		// bulk with sign, junk, cr lf body and extra cr in the trailer
		reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
		queue_text("+A");
		reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_MINUS);
		reply_bytes.push_back(8'hFF);
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_COLON);
		reply_bytes.push_back(CH_LF);
		queue_text("$-1");
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_DOLLAR);
		reply_bytes.push_back(CH_TAB);
		queue_text("-0");
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_STAR);
		reply_bytes.push_back(CH_LF);
		queue_text("$+2z");
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
		reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
		send_queued();

		// random replies; some stretches run without gaps or stalls
		while (bytes_sent < RANDOM_BYTES) begin
			tx_steady = ($urandom_range(0, 5) == 0);
			rx_steady = ($urandom_range(0, 5) == 0);
			queue_element();
			send_queued();
			if (!held && bytes_sent >= RANDOM_BYTES / 2) begin
				drain();
				held = 1;
			end
		end

		tx_steady = 0;
		rx_steady = 0;
		queue_error_tail();
		send_queued();

		drain();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("resp_reply_byte_parser verification clean");
		else
			$display("resp_reply_byte_parser verification failed");
		$finish;
	end

endmodule

`default_nettype wire
